// ----- hdl/rrt_pkg.sv -----
// Shared types and constants for the request retry tracking table.
// Holds the item structs, operation and result kind codes, and register defaults.
// No dependencies.
package rrt_pkg;

    // Default number of table slots.
    localparam int TABLE_SLOTS_DEF = 8;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_SCAN     = 2'd3;

    // Result kinds.
    localparam logic [3:0] K_FULL          = 4'd0;
    localparam logic [3:0] K_STORED_SENT   = 4'd1;
    localparam logic [3:0] K_STORED_UNSENT = 4'd2;
    localparam logic [3:0] K_SENT          = 4'd3;
    localparam logic [3:0] K_RESENT        = 4'd4;
    localparam logic [3:0] K_REFUSED       = 4'd5;
    localparam logic [3:0] K_DROPPED       = 4'd6;
    localparam logic [3:0] K_MATCHED       = 4'd7;
    localparam logic [3:0] K_UNMATCHED     = 4'd8;
    localparam logic [3:0] K_NONE          = 4'd9;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_TRY_LIMIT     = 1'b1;

    // Register reset values.
    localparam logic [7:0] TIMEOUT_RST   = 8'd10;
    localparam logic [3:0] TRY_LIMIT_RST = 4'd3;
    localparam logic [7:0] TIMER_MAX     = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] seq_number;
        logic [7:0] peer_addr;
        logic       queue_ready;
    } in_item_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] slot;
        logic [5:0] entry_seq;
        logic [7:0] entry_addr;
        logic [3:0] tries;
        logic       last;
    } out_item_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [5:0] seq;
        logic [7:0] addr;
        logic [3:0] cnt;
        logic [7:0] timer;
    } entry_t;

endpackage

// ----- hdl/request_retry_tracking_table.sv -----
// Top level of the request retry tracking table.
// Holds the entry memory, the occupancy flags, the slot walker and the output stage.
// Depends on rrt_pkg.

// The block keeps up to TABLE_SLOTS outstanding bus requests. A new request
// item is stored in the lowest free slot in the cycle it is accepted and its
// single result is registered at once. A response, a timer tick or a service
// scan walks the slots through the registered read port of the entry memory,
// one read a cycle while the output is not held off; a response ends early
// when it matches and a scan when it sends or refuses. The entry memory has a
// single read port. Results of one item leave in table order; the final one
// carries last. Occupancy flags are cleared by reset; the entry memory itself
// needs no clearing, since an entry is only looked at while its slot is
// occupied. Configuration writes are taken in any cycle but are meant to come
// only while the block is idle.
module request_retry_tracking_table
    import rrt_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Entry memory: sequence, address, send count and age timer per slot.
    entry_t mem [TABLE_SLOTS];

    logic [1:0]             state_reg, state_next;
    logic [TABLE_SLOTS-1:0] occ_reg, occ_next;
    logic [7:0]             tmo_reg;
    logic [3:0]             lim_reg;

    // The item being worked on.
    logic [1:0] op_reg, op_next;
    logic [5:0] seq_reg, seq_next;
    logic [7:0] addr_reg, addr_next;
    logic       qrdy_reg, qrdy_next;

    // Walker: read address, and the slot whose data sits in the read register.
    logic [IW-1:0] walk_idx_reg, walk_idx_next;
    logic          issue_reg, issue_next;
    logic          eval_vld_reg, eval_vld_next;
    logic [IW-1:0] eval_idx_reg, eval_idx_next;
    entry_t        rd_data_reg;

    // A result waits in the hold stage until it is known whether it is the last.
    logic      hold_vld_reg, hold_vld_next;
    out_item_t hold_reg, hold_next;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_reg, out_next;

    logic      out_free;
    logic      in_acc;
    logic      free_found;
    logic [IW-1:0] free_idx;

    logic      res_vld;
    out_item_t res;
    logic      finish;
    logic      eval_wr;
    entry_t    eval_entry;
    logic      occ_clr;
    logic      at_end;
    logic      stall;
    logic      advance;
    logic      rd_en;
    logic      eval_occ;
    entry_t    ent;
    out_item_t dflt;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    assign out_free  = !out_vld_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Evaluation of the slot whose entry has just been read.
    always_comb
    begin
        ent        = rd_data_reg;
        eval_occ   = occ_reg[eval_idx_reg];
        res_vld    = 1'b0;
        res        = '0;
        finish     = 1'b0;
        eval_wr    = 1'b0;
        eval_entry = ent;
        occ_clr    = 1'b0;

        res.slot       = 5'(eval_idx_reg);
        res.entry_seq  = ent.seq;
        res.entry_addr = ent.addr;
        res.tries      = ent.cnt;

        if (eval_vld_reg && eval_occ)
        begin
            case (op_reg)
                OP_RESPONSE:
                begin
                    if (ent.seq == seq_reg && ent.addr == addr_reg)
                    begin
                        res_vld  = 1'b1;
                        res.kind = K_MATCHED;
                        finish   = 1'b1;
                        occ_clr  = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (ent.cnt != 4'd0 && ent.timer != TIMER_MAX)
                    begin
                        eval_wr          = 1'b1;
                        eval_entry.timer = ent.timer + 8'd1;
                    end
                end
                OP_SCAN:
                begin
                    if (ent.cnt == 4'd0)
                    begin
                        // First send of an entry stored while the queue was busy.
                        res_vld = 1'b1;
                        finish  = 1'b1;
                        if (qrdy_reg)
                        begin
                            eval_wr          = 1'b1;
                            eval_entry.timer = 8'd0;
                            eval_entry.cnt   = 4'd1;
                            res.kind         = K_SENT;
                            res.tries        = 4'd1;
                        end
                        else
                        begin
                            res.kind = K_REFUSED;
                        end
                    end
                    else if (ent.timer >= tmo_reg)
                    begin
                        if (ent.cnt >= lim_reg)
                        begin
                            res_vld  = 1'b1;
                            res.kind = K_DROPPED;
                            occ_clr  = 1'b1;
                        end
                        else
                        begin
                            res_vld = 1'b1;
                            finish  = 1'b1;
                            if (qrdy_reg)
                            begin
                                eval_wr          = 1'b1;
                                eval_entry.timer = 8'd0;
                                eval_entry.cnt   = ent.cnt + 4'd1;
                                res.kind         = K_RESENT;
                                res.tries        = ent.cnt + 4'd1;
                            end
                            else
                            begin
                                res.kind = K_REFUSED;
                            end
                        end
                    end
                end
                default:
                begin
                    res_vld = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        dflt = '0;
        if (op_reg == OP_RESPONSE)
        begin
            dflt.kind       = K_UNMATCHED;
            dflt.entry_seq  = seq_reg;
            dflt.entry_addr = addr_reg;
        end
        else
        begin
            dflt.kind = K_NONE;
        end
    end

    assign at_end  = eval_vld_reg && (eval_idx_reg == LAST_IDX);
    assign stall   = res_vld && hold_vld_reg && !out_free;
    assign advance = (state_reg == ST_WALK) && !stall;
    assign rd_en   = advance && issue_reg;

    // Next-state logic for control, walker, hold stage and output register.
    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        op_next       = op_reg;
        seq_next      = seq_reg;
        addr_next     = addr_reg;
        qrdy_next     = qrdy_reg;
        walk_idx_next = walk_idx_reg;
        issue_next    = issue_reg;
        eval_vld_next = eval_vld_reg;
        eval_idx_next = eval_idx_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        wr_en         = 1'b0;
        wr_addr       = eval_idx_reg;
        wr_data       = eval_entry;

        if (out_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = in_data.operation;
                    seq_next  = in_data.seq_number;
                    addr_next = in_data.peer_addr;
                    qrdy_next = in_data.queue_ready;
                    if (in_data.operation == OP_REQUEST)
                    begin
                        out_vld_next        = 1'b1;
                        out_next            = '0;
                        out_next.last       = 1'b1;
                        out_next.entry_seq  = in_data.seq_number;
                        out_next.entry_addr = in_data.peer_addr;
                        if (free_found)
                        begin
                            wr_en                   = 1'b1;
                            wr_addr                 = free_idx;
                            wr_data.seq             = in_data.seq_number;
                            wr_data.addr            = in_data.peer_addr;
                            wr_data.timer           = 8'd0;
                            wr_data.cnt             = {3'd0, in_data.queue_ready};
                            occ_next[free_idx]      = 1'b1;
                            out_next.slot           = 5'(free_idx);
                            out_next.tries          = {3'd0, in_data.queue_ready};
                            out_next.kind           = in_data.queue_ready ?
                                                      K_STORED_SENT : K_STORED_UNSENT;
                        end
                        else
                        begin
                            out_next.kind = K_FULL;
                        end
                    end
                    else
                    begin
                        state_next    = ST_WALK;
                        walk_idx_next = '0;
                        issue_next    = 1'b1;
                        eval_vld_next = 1'b0;
                        hold_vld_next = 1'b0;
                    end
                end
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    eval_vld_next = rd_en;
                    eval_idx_next = walk_idx_reg;
                    if (rd_en)
                    begin
                        if (walk_idx_reg == LAST_IDX)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            walk_idx_next = walk_idx_reg + IW'(1);
                        end
                    end
                    wr_en = eval_wr;
                    if (occ_clr)
                    begin
                        occ_next[eval_idx_reg] = 1'b0;
                    end
                    if (res_vld)
                    begin
                        if (hold_vld_reg)
                        begin
                            // The held result is not the last one: release it.
                            out_vld_next  = 1'b1;
                            out_next      = hold_reg;
                            out_next.last = 1'b0;
                        end
                        hold_vld_next = 1'b1;
                        hold_next     = res;
                    end
                    else if (at_end && !hold_vld_reg)
                    begin
                        hold_vld_next = 1'b1;
                        hold_next     = dflt;
                    end
                    if (finish || at_end)
                    begin
                        state_next    = ST_FLUSH;
                        issue_next    = 1'b0;
                        eval_vld_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_next      = hold_reg;
                    out_next.last = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[walk_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            tmo_reg      <= TIMEOUT_RST;
            lim_reg      <= TRY_LIMIT_RST;
            issue_reg    <= 1'b0;
            eval_vld_reg <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            issue_reg    <= issue_next;
            eval_vld_reg <= eval_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS: tmo_reg <= cfg_data;
                    CFG_TRY_LIMIT:     lim_reg <= cfg_data[3:0];
                    default:           tmo_reg <= tmo_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        seq_reg      <= seq_next;
        addr_reg     <= addr_next;
        qrdy_reg     <= qrdy_next;
        walk_idx_reg <= walk_idx_next;
        eval_idx_reg <= eval_idx_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
    end

endmodule
